// ----- rtl/sst_pkg.sv -----
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the sorted score table.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int Depth     = 16;
  localparam int IdBits    = 32;
  localparam int ScoreBits = 31;
  localparam int IdxBits   = $clog2(Depth);
  localparam int CntBits   = $clog2(Depth + 1);

  typedef logic [IdBits-1:0]    id_t;
  typedef logic [ScoreBits-1:0] score_t;
  typedef logic [IdxBits-1:0]   idx_t;
  typedef logic [CntBits-1:0]   cnt_t;

  typedef enum logic [2:0] {
    FUNC_ADD    = 3'd0,
    FUNC_RAISE  = 3'd1,
    FUNC_POP    = 3'd2,
    FUNC_REMOVE = 3'd3,
    FUNC_CLEAR  = 3'd4,
    FUNC_QUERY  = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_APPLY,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic find;
    logic apply;
  } cmd_t;

endpackage

// ----- rtl/sst_datapath.sv -----
// ----------------------------------------------------------------------------
// sst_datapath
// Entry table with parallel compares: lookup, then one remove/insert/move.
// ----------------------------------------------------------------------------
module sst_datapath (
  input  logic               clk,
  input  logic               rst,
  input  sst_pkg::cmd_t      cmd,
  input  logic [2:0]         func_in,
  input  sst_pkg::id_t       id_in,
  input  logic [31:0]        amount_in,
  output logic               res_pos_valid,
  output sst_pkg::cnt_t      res_pos,
  output logic               res_top_valid,
  output sst_pkg::id_t       res_top_id,
  output sst_pkg::score_t    res_top_score,
  output sst_pkg::cnt_t      res_count
);

  localparam int N = sst_pkg::Depth;
  localparam int W = sst_pkg::ScoreBits;

  sst_pkg::id_t    ids    [N];
  sst_pkg::score_t scores [N];
  sst_pkg::cnt_t   count;

  logic [2:0]       func_r;
  sst_pkg::id_t     id_r;
  logic             neg_r;
  logic [31:0]      mag_r;

  // lookup results
  logic             hit;
  sst_pkg::idx_t    hit_idx;
  sst_pkg::score_t  hit_score;
  sst_pkg::score_t  top_score_r;

  logic             find_hit;
  sst_pkg::idx_t    find_idx;
  sst_pkg::score_t  find_score;

  // apply plan
  logic             do_rem, do_ins, pos_valid;
  sst_pkg::idx_t    rem_idx;
  sst_pkg::score_t  new_score;
  logic             up_tie;
  sst_pkg::cnt_t    pos;

  logic [N-1:0]     match;
  logic [W-1:0]     mag_clip;

  // shifted views for remove and insert
  sst_pkg::cnt_t    cnt_after;
  sst_pkg::cnt_t    ins_pos;
  logic [N-1:0]     ge;
  sst_pkg::id_t     iv          [N];
  sst_pkg::score_t  sv          [N];
  sst_pkg::id_t     ids_next    [N];
  sst_pkg::score_t  scores_next [N];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      match[i] = (sst_pkg::cnt_t'(i) < count) && (ids[i] == id_r);
    end
  end

  always_comb begin
    find_hit   = 1'b0;
    find_idx   = '0;
    find_score = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) begin
        find_hit   = 1'b1;
        find_idx   = sst_pkg::idx_t'(i);
        find_score = scores[i];
      end
    end
  end

  function automatic sst_pkg::score_t sat(input logic [W-1:0] a, input logic [31:0] m);
    logic [32:0] s;
    logic [32:0] mx;
    s  = 33'(a) + 33'(m);
    mx = 33'({W{1'b1}});
    sat = (s > mx) ? {W{1'b1}} : s[W-1:0];
  endfunction

  always_comb begin
    mag_clip = (mag_r > 32'({W{1'b1}})) ? {W{1'b1}} : mag_r[W-1:0];
  end

  // insert position is computed over the table with the removed entry gone
  always_comb begin
    for (int i = 0; i < N - 1; i++) begin
      if (do_rem && sst_pkg::idx_t'(i) >= rem_idx) begin
        iv[i] = ids[i+1];
        sv[i] = scores[i+1];
      end else begin
        iv[i] = ids[i];
        sv[i] = scores[i];
      end
    end
    iv[N-1] = ids[N-1];
    sv[N-1] = scores[N-1];
  end

  always_comb begin
    cnt_after = count - sst_pkg::cnt_t'(do_rem);
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ge[i] = (sst_pkg::cnt_t'(i) < cnt_after) && (sv[i] >= new_score);
    end
    ins_pos = '0;
    for (int i = 0; i < N; i++) begin
      if (ge[i] && !(up_tie && sv[i] == new_score)) ins_pos = sst_pkg::cnt_t'(i + 1);
    end
  end

  always_comb begin
    ids_next[0]    = iv[0];
    scores_next[0] = sv[0];
    if (do_ins && ins_pos == '0) begin
      ids_next[0]    = id_r;
      scores_next[0] = new_score;
    end
    for (int i = 1; i < N; i++) begin
      ids_next[i]    = iv[i];
      scores_next[i] = sv[i];
      if (do_ins && sst_pkg::cnt_t'(i) == ins_pos) begin
        ids_next[i]    = id_r;
        scores_next[i] = new_score;
      end else if (do_ins && sst_pkg::cnt_t'(i) > ins_pos) begin
        ids_next[i]    = iv[i-1];
        scores_next[i] = sv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (cmd.load) begin
        func_r <= func_in;
        id_r   <= id_in;
        neg_r  <= amount_in[31];
        mag_r  <= amount_in[31] ? (~amount_in + 32'd1) : amount_in;
      end
      if (cmd.find) begin
        hit         <= find_hit;
        hit_idx     <= find_idx;
        hit_score   <= find_score;
        top_score_r <= scores[0];
        if (func_r == sst_pkg::FUNC_RAISE && neg_r) mag_r <= '0;
      end
      if (cmd.apply) begin
        for (int i = 0; i < N; i++) begin
          ids[i]    <= ids_next[i];
          scores[i] <= scores_next[i];
        end
        if (func_r == sst_pkg::FUNC_CLEAR) count <= '0;
        else count <= cnt_after + sst_pkg::cnt_t'(do_ins);
        res_pos_valid <= pos_valid;
        res_pos       <= pos_valid ? pos : '0;
      end
    end
  end

  // plan the operation from lookup results
  always_comb begin
    do_rem    = 1'b0;
    do_ins    = 1'b0;
    pos_valid = 1'b0;
    rem_idx   = hit_idx;
    new_score = '0;
    up_tie    = 1'b0;
    pos       = '0;
    case (func_r)
      sst_pkg::FUNC_ADD: begin
        if (mag_r != '0) begin
          if (hit) begin
            pos_valid = 1'b1;
            do_rem    = 1'b1;
            if (!neg_r) begin
              new_score = sat(hit_score, mag_r);
              do_ins = 1'b1;
              up_tie = 1'b1;
            end else if (mag_r >= 32'(hit_score)) begin
              pos = sst_pkg::cnt_t'(hit_idx);
            end else begin
              new_score = hit_score - mag_r[W-1:0];
              do_ins = 1'b1;
            end
          end else if (!neg_r) begin
            pos_valid = 1'b1;
            do_ins    = 1'b1;
            new_score = mag_clip;
            if (count == sst_pkg::cnt_t'(N)) begin
              do_rem  = 1'b1;
              rem_idx = sst_pkg::idx_t'(N - 1);
            end
          end
        end
      end
      sst_pkg::FUNC_RAISE: begin
        if (hit) begin
          if (!(mag_r == '0 && hit_score == top_score_r)) begin
            pos_valid = 1'b1;
            do_rem    = 1'b1;
            do_ins    = 1'b1;
            up_tie    = 1'b1;
            new_score = sat(top_score_r, mag_r);
          end
        end else if (count == '0) begin
          if (mag_r != '0) begin
            pos_valid = 1'b1;
            do_ins    = 1'b1;
            new_score = mag_clip;
          end
        end else begin
          pos_valid = 1'b1;
          do_ins    = 1'b1;
          new_score = sat(top_score_r, mag_r);
          if (count == sst_pkg::cnt_t'(N)) begin
            do_rem  = 1'b1;
            rem_idx = sst_pkg::idx_t'(N - 1);
          end
        end
      end
      sst_pkg::FUNC_POP: begin
        if (count != '0) begin
          pos_valid = 1'b1;
          do_rem    = 1'b1;
          rem_idx   = '0;
        end
      end
      sst_pkg::FUNC_REMOVE: begin
        if (hit) begin
          pos_valid = 1'b1;
          do_rem    = 1'b1;
          pos       = sst_pkg::cnt_t'(hit_idx);
        end
      end
      default: ;
    endcase
    if (do_ins) pos = ins_pos;
  end

  assign res_count     = count;
  assign res_top_valid = (count != '0);
  assign res_top_id    = (count != '0) ? ids[0] : '0;
  assign res_top_score = (count != '0) ? scores[0] : '0;

endmodule

// ----- rtl/sst_ctrl.sv -----
// ----------------------------------------------------------------------------
// sst_ctrl
// Sequencer: load, lookup, apply, present result.
// ----------------------------------------------------------------------------
module sst_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output sst_pkg::cmd_t cmd
);

  sst_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= sst_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      sst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sst_pkg::ST_FIND;
        end
      end
      sst_pkg::ST_FIND: begin
        cmd.find   = 1'b1;
        state_next = sst_pkg::ST_APPLY;
      end
      sst_pkg::ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = sst_pkg::ST_OUT;
      end
      sst_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = sst_pkg::ST_IDLE;
      end
      default: state_next = sst_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/sorted_score_table_top.sv -----
// ----------------------------------------------------------------------------
// sorted_score_table_top
// Bounded table of (id, score) entries kept in descending score order.
// each input word passes load, lookup and apply, then its result word is held
// until taken; a new input word is accepted only after that result is taken
// reset: synchronous, empties the table; entry contents stay undefined
// ----------------------------------------------------------------------------
module sorted_score_table_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [71:0]  s_tdata,   // func[2:0], id[34:3], amount[66:35]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata    // position_valid, position, top_valid, top_id,
                                  // top_score, entry_count
);

  sst_pkg::cmd_t   cmd;
  logic            pv, tv;
  sst_pkg::cnt_t   pos, cnt;
  sst_pkg::id_t    tid;
  sst_pkg::score_t tsc;

  sst_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .cmd(cmd)
  );

  sst_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .func_in(s_tdata[2:0]), .id_in(s_tdata[34:3]), .amount_in(s_tdata[66:35]),
    .res_pos_valid(pv), .res_pos(pos), .res_top_valid(tv),
    .res_top_id(tid), .res_top_score(tsc), .res_count(cnt)
  );

  assign m_tdata = {5'd0, cnt, tsc, tid, tv, pos, pv};

endmodule

// ----- tb/sorted_score_table_top_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_score_table_top_tb
// Drives add, raise, pop, remove, clear and query words into the score table,
// tracks the sorted table in a local model and checks every result word
// field by field, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module sorted_score_table_top_tb;

  localparam longint ScoreMax = (64'd1 << sst_pkg::ScoreBits) - 1;
  localparam int     CycleLimit = 400000;

  typedef struct {
    bit        pos_valid;
    bit [4:0]  pos;
    bit        top_valid;
    bit [31:0] top_id;
    bit [30:0] top_score;
    bit [4:0]  count;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;

  // table shadow
  bit [31:0] tbl_id [sst_pkg::Depth];
  longint    tbl_score [sst_pkg::Depth];
  int        tbl_count;

  table_result_t pending_q[$];
  int  err_count;
  int  words_sent;
  int  words_checked;
  int  cycle_count;
  int  rx_stall;
  bit  rx_hold;
  bit  rx_quiet;
  bit [31:0] id_pool [20];

  sorted_score_table_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("sorted_score_table_top_tb: errors");
      $finish;
    end
  end

  function automatic int find_slot(bit [31:0] id);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(int i);
    for (int k = i; k + 1 < tbl_count; k++) begin
      tbl_id[k] = tbl_id[k+1];
      tbl_score[k] = tbl_score[k+1];
    end
    if (tbl_count > 0) tbl_count--;
  endfunction

  function automatic int place_new(bit [31:0] id, longint score);
    int p;
    p = 0;
    if (tbl_count >= sst_pkg::Depth) tbl_count = sst_pkg::Depth - 1;
    while (p < tbl_count && tbl_score[p] >= score) p++;
    for (int k = tbl_count; k > p; k--) begin
      tbl_id[k] = tbl_id[k-1];
      tbl_score[k] = tbl_score[k-1];
    end
    tbl_id[p] = id;
    tbl_score[p] = score;
    tbl_count++;
    return p;
  endfunction

  function automatic int shift_up(int i, longint score);
    bit [31:0] id;
    int j;
    id = tbl_id[i];
    j = i;
    while (j > 0 && tbl_score[j-1] <= score) begin
      tbl_id[j] = tbl_id[j-1];
      tbl_score[j] = tbl_score[j-1];
      j--;
    end
    tbl_id[j] = id;
    tbl_score[j] = score;
    return j;
  endfunction

  function automatic int shift_down(int i, longint score);
    bit [31:0] id;
    int j;
    id = tbl_id[i];
    j = i;
    while (j + 1 < tbl_count && tbl_score[j+1] >= score) begin
      tbl_id[j] = tbl_id[j+1];
      tbl_score[j] = tbl_score[j+1];
      j++;
    end
    tbl_id[j] = id;
    tbl_score[j] = score;
    return j;
  endfunction

  function automatic longint clip_sum(longint a, longint b);
    return (a + b > ScoreMax) ? ScoreMax : a + b;
  endfunction

  function automatic table_result_t apply_word(logic [2:0] func, bit [31:0] id,
                                               bit [31:0] amount);
    table_result_t r;
    bit     neg;
    longint mag;
    int     f;
    bit     ok;
    int     p;
    neg = amount[31];
    mag = neg ? (64'h1_0000_0000 - longint'(amount)) : longint'(amount);
    ok = 1'b0;
    p = 0;
    case (func)
      sst_pkg::FUNC_ADD: begin
        if (mag != 0) begin
          f = find_slot(id);
          if (f >= 0) begin
            ok = 1'b1;
            if (!neg) p = shift_up(f, clip_sum(tbl_score[f], mag));
            else if (mag >= tbl_score[f]) begin
              drop_slot(f);
              p = f;
            end else p = shift_down(f, tbl_score[f] - mag);
          end else if (!neg) begin
            p = place_new(id, mag > ScoreMax ? ScoreMax : mag);
            ok = 1'b1;
          end
        end
      end
      sst_pkg::FUNC_RAISE: begin
        if (neg) mag = 0;
        f = find_slot(id);
        if (f >= 0) begin
          if (!(mag == 0 && tbl_score[f] == tbl_score[0])) begin
            p = shift_up(f, clip_sum(tbl_score[0], mag));
            ok = 1'b1;
          end
        end else if (tbl_count == 0) begin
          if (mag != 0) begin
            p = place_new(id, mag > ScoreMax ? ScoreMax : mag);
            ok = 1'b1;
          end
        end else begin
          p = place_new(id, clip_sum(tbl_score[0], mag));
          ok = 1'b1;
        end
      end
      sst_pkg::FUNC_POP: begin
        if (tbl_count > 0) begin
          drop_slot(0);
          ok = 1'b1;
        end
      end
      sst_pkg::FUNC_REMOVE: begin
        f = find_slot(id);
        if (f >= 0) begin
          drop_slot(f);
          p = f;
          ok = 1'b1;
        end
      end
      sst_pkg::FUNC_CLEAR: tbl_count = 0;
      default: ;
    endcase
    r.pos_valid = ok;
    r.pos       = ok ? p[4:0] : 5'd0;
    r.top_valid = tbl_count > 0;
    r.top_id    = tbl_count > 0 ? tbl_id[0] : 32'd0;
    r.top_score = tbl_count > 0 ? tbl_score[0][30:0] : 31'd0;
    r.count     = tbl_count[4:0];
    return r;
  endfunction

  task automatic send_word(logic [2:0] func, bit [31:0] id, bit [31:0] amount);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, amount, id, func};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_q.push_back(apply_word(func, id, amount));
    words_sent++;
  endtask

  // result checker
  always @(posedge clk) begin
    table_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result word %h", m_tdata);
        err_count++;
      end else begin
        e = pending_q.pop_front();
        words_checked++;
        if (m_tdata[0] !== e.pos_valid) begin
          $error("position_valid exp %0d got %0d", e.pos_valid, m_tdata[0]);
          err_count++;
        end
        if (m_tdata[5:1] !== e.pos) begin
          $error("position exp %0d got %0d", e.pos, m_tdata[5:1]);
          err_count++;
        end
        if (m_tdata[6] !== e.top_valid) begin
          $error("top_valid exp %0d got %0d", e.top_valid, m_tdata[6]);
          err_count++;
        end
        if (m_tdata[38:7] !== e.top_id) begin
          $error("top_id exp %h got %h", e.top_id, m_tdata[38:7]);
          err_count++;
        end
        if (m_tdata[69:39] !== e.top_score) begin
          $error("top_score exp %0d got %0d", e.top_score, m_tdata[69:39]);
          err_count++;
        end
        if (m_tdata[74:70] !== e.count) begin
          $error("entry_count exp %0d got %0d", e.count, m_tdata[74:70]);
          err_count++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst || rx_hold) begin
      m_tready <= 1'b0;
    end else if (m_tvalid && m_tready && !rx_quiet && $urandom_range(0, 1)) begin
      rx_stall = $urandom_range(1, 7);
      m_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic bit [31:0] pick_id();
    return ($urandom_range(0, 9) == 0) ? $urandom : id_pool[$urandom_range(0, 19)];
  endfunction

  function automatic bit [31:0] pick_amount();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3, 4: return -$urandom_range(1, 60);
      5: return 32'd0;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  task automatic random_word();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 48) send_word(sst_pkg::FUNC_ADD, pick_id(), pick_amount());
    else if (sel < 60) send_word(sst_pkg::FUNC_RAISE, pick_id(), pick_amount());
    else if (sel < 70) send_word(sst_pkg::FUNC_POP, pick_id(), pick_amount());
    else if (sel < 86) send_word(sst_pkg::FUNC_REMOVE, pick_id(), pick_amount());
    else if (sel < 88) send_word(sst_pkg::FUNC_CLEAR, pick_id(), pick_amount());
    else send_word(3'($urandom_range(5, 7)), pick_id(), pick_amount());
  endtask

  task automatic test_directed();
    send_word(sst_pkg::FUNC_POP, 32'd0, 32'd0);
    send_word(sst_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 32'd0);
    send_word(sst_pkg::FUNC_RAISE, 32'd5, 32'd0);
    send_word(sst_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'h8000_0000);
    send_word(sst_pkg::FUNC_ADD, 32'd0, 32'h7FFF_FFFF);
    send_word(sst_pkg::FUNC_ADD, 32'd0, 32'd10);
    send_word(sst_pkg::FUNC_ADD, 32'd0, 32'd0);
    send_word(sst_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'd100);
    send_word(sst_pkg::FUNC_ADD, 32'd7, 32'd100);
    send_word(sst_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send_word(sst_pkg::FUNC_ADD, 32'd7, -32'd1);
    send_word(sst_pkg::FUNC_RAISE, 32'd0, 32'd0);
    send_word(sst_pkg::FUNC_RAISE, 32'd7, 32'h8000_0000);
    send_word(sst_pkg::FUNC_RAISE, 32'd9, 32'd3);
    send_word(sst_pkg::FUNC_ADD, 32'd0, 32'h8000_0000);
    send_word(sst_pkg::FUNC_REMOVE, 32'd9, 32'd0);
    send_word(sst_pkg::FUNC_POP, 32'd0, 32'd0);
    send_word(3'd6, 32'd0, 32'd0);
    send_word(3'd7, 32'd0, 32'd0);
    send_word(sst_pkg::FUNC_QUERY, 32'd0, 32'd0);
    for (int i = 0; i < 18; i++) send_word(sst_pkg::FUNC_ADD, 32'd100 + i, 32'd50 - i);
    send_word(sst_pkg::FUNC_CLEAR, 32'd0, 32'd0);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      rx_quiet = (i % 200) < 40;
      random_word();
    end
    rx_quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        rx_hold = 1'b0;
      end
      for (int i = 0; i < 40; i++) random_word();
    join
  endtask

  initial begin
    err_count = 0;
    words_sent = 0;
    words_checked = 0;
    cycle_count = 0;
    rx_stall = 0;
    rx_hold = 1'b0;
    rx_quiet = 1'b0;
    tbl_count = 0;
    foreach (id_pool[i]) id_pool[i] = (i < 2) ? {32{i[0]}} : $urandom;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(600);
    test_backpressure();
    test_random(650);
    @(posedge clk);
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("run covered %0d words of all six operations, %0d results checked",
             words_sent, words_checked);
    $display("with random gaps, full-table drops and a long output stall");
    if (err_count == 0) begin
      $display("sorted_score_table_top_tb: clean");
    end else begin
      $display("sorted_score_table_top_tb: errors");
    end
    $finish;
  end

endmodule
